/* rtl/sliding_window_ls_velocity_2d_core_macros.svh */
// Assertion macros used by the core RTL file
`ifndef SLIDING_WINDOW_LS_VELOCITY_2D_CORE_MACROS_SVH
`define SLIDING_WINDOW_LS_VELOCITY_2D_CORE_MACROS_SVH
`ifndef SYNTH
`define SWV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SWV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SWV_ASSERT_NOW(label, ante, cons)
`define SWV_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/swv_pkg.sv */
// ---------------------------------------------------------------------------
// swv_pkg
// Types and constants of the sliding-window slope estimator.
// ---------------------------------------------------------------------------
package swv_pkg;

  localparam int unsigned WIN_MAX = 32;
  localparam logic [19:0] SCALE   = 20'd1000000;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [31:0] timestamp;
  } swv_in_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               valid_res;
  } swv_out_t;

  typedef struct packed {
    logic        [31:0] t;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } swv_smp_t;

  // control from the sequencer to each coordinate lane
  typedef struct packed {
    logic       clr;
    logic       inc2;
    logic       mul_ld;
    logic       mul_en;
    logic       mul_bit;
    logic       form;
    logic       scl_en;
    logic [4:0] scl_idx;
    logic       div_en;
  } swv_ctl_t;

endpackage

/* rtl/swv_cell.sv */
// ---------------------------------------------------------------------------
// swv_cell
// One window slot: loads the neighbor's sample when the chain moves.
// ---------------------------------------------------------------------------
module swv_cell
  import swv_pkg::*;
(
  input  logic     clk,
  input  logic     en,
  input  swv_smp_t d,
  output swv_smp_t q
);

  swv_smp_t smp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      smp_r <= d;
    end
  end

  assign q = smp_r;

endmodule

/* rtl/swv_lane.sv */
// ---------------------------------------------------------------------------
// swv_lane
// One coordinate: sums, serial products, scaling and restoring division.
// ---------------------------------------------------------------------------
module swv_lane
  import swv_pkg::*;
(
  input  logic               clk,
  input  swv_ctl_t           ctl,
  input  logic signed [31:0] val,
  input  logic        [31:0] dt1,
  input  logic        [5:0]  n,
  input  logic        [74:0] den,
  output logic signed [31:0] vel
);

  logic signed [31:0] v1_r, v2_r;
  logic signed [64:0] prod2_r;
  logic signed [36:0] sv_r;
  logic signed [69:0] stv_r;
  logic signed [73:0] mc_r, pacc_r;
  logic signed [76:0] num;
  logic        [76:0] mag;
  logic        [96:0] smc_r, sacc_r;
  logic        [74:0] rem_r, rem_nxt;
  logic        [75:0] trial;
  logic               ge;
  logic        [32:0] q_r;
  logic               ovf_r, neg_r;

  assign num   = 77'($signed({1'b0, n})) * 77'(stv_r) - 77'(pacc_r);
  assign mag   = num[76] ? 77'(-num) : 77'(num);
  assign trial = {rem_r, sacc_r[96]};
  assign ge    = trial >= {1'b0, den};
  assign rem_nxt = ge ? 75'(trial - {1'b0, den}) : trial[74:0];

  always_ff @(posedge clk) begin
    v1_r    <= val;
    v2_r    <= v1_r;
    prod2_r <= 65'($signed({1'b0, dt1})) * 65'(v1_r);
    if (ctl.clr) begin
      sv_r  <= '0;
      stv_r <= '0;
    end else if (ctl.inc2) begin
      sv_r  <= sv_r + 37'(v2_r);
      stv_r <= stv_r + 70'(prod2_r);
    end
    if (ctl.mul_ld) begin
      mc_r   <= 74'(sv_r);
      pacc_r <= '0;
    end else if (ctl.mul_en) begin
      if (ctl.mul_bit) begin
        pacc_r <= pacc_r + mc_r;
      end
      mc_r <= mc_r <<< 1;
    end
    if (ctl.form) begin
      neg_r  <= num[76];
      smc_r  <= {20'd0, mag};
      sacc_r <= '0;
      rem_r  <= '0;
      q_r    <= '0;
      ovf_r  <= 1'b0;
    end else if (ctl.scl_en) begin
      if (SCALE[ctl.scl_idx]) begin
        sacc_r <= sacc_r + smc_r;
      end
      smc_r <= smc_r << 1;
    end else if (ctl.div_en) begin
      rem_r  <= rem_nxt;
      sacc_r <= sacc_r << 1;
      q_r    <= {q_r[31:0], ge};
      ovf_r  <= ovf_r | q_r[32];
    end
  end

  // saturate the truncated quotient; zero when the denominator is zero
  always_comb begin
    if (den == '0) begin
      vel = '0;
    end else if (neg_r) begin
      if (ovf_r || q_r > 33'h080000000) begin
        vel = 32'sh80000000;
      end else begin
        vel = 32'(-$signed(q_r[31:0]));
      end
    end else if (ovf_r || q_r[32] || q_r[31]) begin
      vel = 32'sh7FFFFFFF;
    end else begin
      vel = $signed(q_r[31:0]);
    end
  end

endmodule

/* rtl/sliding_window_ls_velocity_2d_core.sv */
// Flow once the window is full: an accepted word runs through the rotation, drain,
// product, form, scale, divide and output states in that order; while the window
// is still filling it goes straight to the output state.
// The next word waits for the idle state, so a word is finished before another is
// taken; the output state waits while a held result is stalled.
// Reset (rst_n low, synchronous): ring empty, window not full, window_length = 8.
// ---------------------------------------------------------------------------
// sliding_window_ls_velocity_2d_core
// Least-squares slope of x(t) and y(t), scaled by 1000000, over the last window_length samples (clamped to 1..32).
// ---------------------------------------------------------------------------
`include "sliding_window_ls_velocity_2d_core_macros.svh"
module sliding_window_ls_velocity_2d_core
  import swv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  swv_in_t   in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output swv_out_t  out_data,
  input  logic      cfg_we,
  input  logic [5:0] cfg_wdata
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_ROT  = 8'b0000_0010,
    ST_FLSH = 8'b0000_0100,
    ST_MUL  = 8'b0000_1000,
    ST_FORM = 8'b0001_0000,
    ST_SCL  = 8'b0010_0000,
    ST_DIV  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

  state_t   state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [5:0] wlen_r, fill_r, fill_nxt, len, n_r, n_nxt;
  logic       full_r, full_nxt;
  logic       accept;

  // Chain of window cells: cell 0 is the newest sample. An accepted word
  // shifts in at cell 0; during the fit the chain rotates once (tail back
  // to head) so the tail presents every sample, oldest in window first.
  swv_smp_t cell_q [WIN_MAX];
  swv_smp_t head_d, tail;
  logic     chain_en;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign tail     = cell_q[WIN_MAX-1];
  assign chain_en = accept || (state_r == ST_ROT);

  always_comb begin
    if (state_r == ST_IDLE) begin
      head_d = '{t: in_data.timestamp, x: in_data.pos_x, y: in_data.pos_y};
    end else begin
      head_d = tail;
    end
  end

  for (genvar g = 0; g < WIN_MAX; g++) begin : g_cell
    swv_cell u_cell (
      .clk (clk),
      .en  (chain_en),
      .d   ((g == 0) ? head_d : cell_q[(g == 0) ? 0 : g-1]),
      .q   (cell_q[g])
    );
  end

  // Clamp the window length and update fill bookkeeping on accept.
  always_comb begin
    if (wlen_r == '0) begin
      len = 6'd1;
    end else if (wlen_r > 6'(WIN_MAX)) begin
      len = 6'(WIN_MAX);
    end else begin
      len = wlen_r;
    end
    fill_nxt = (fill_r < 6'(WIN_MAX)) ? fill_r + 6'd1 : fill_r;
    n_nxt    = (fill_nxt < len) ? fill_nxt : len;
    full_nxt = full_r || (fill_nxt >= len);
  end

  // Rotation front end: sample k of the rotation is in the window once
  // k + n reaches the depth; the first such one is the time origin.
  logic [5:0]  kpn;
  logic        incl, first;
  logic [31:0] t0_r, t0_sel, dt1_r, dt2_r;
  logic        inc1_r, inc2_r;
  logic [63:0] tt2_r;
  logic [36:0] st_r, st_sh_r;
  logic [68:0] stt_r;
  logic [73:0] sq_mc_r, sq_r;
  logic [74:0] den_r;

  assign kpn    = {1'b0, cnt_r[4:0]} + n_r;
  assign incl   = (state_r == ST_ROT) && (kpn >= 6'(WIN_MAX));
  assign first  = (state_r == ST_ROT) && (kpn == 6'(WIN_MAX));
  assign t0_sel = first ? tail.t : t0_r;

  always_ff @(posedge clk) begin
    t0_r  <= t0_sel;
    dt1_r <= tail.t - t0_sel;
    dt2_r <= dt1_r;
    tt2_r <= 64'(dt1_r) * 64'(dt1_r);
    if (accept) begin
      st_r  <= '0;
      stt_r <= '0;
    end else if (inc2_r) begin
      st_r  <= st_r + 37'(dt2_r);
      stt_r <= stt_r + 69'(tt2_r);
    end
    // St*St, bit-serial over St; the lanes share the same bit
    if (state_r == ST_MUL && cnt_r == '0) begin
      st_sh_r <= st_r;
      sq_mc_r <= 74'(st_r);
      sq_r    <= '0;
    end else if (state_r == ST_MUL) begin
      if (st_sh_r[0]) begin
        sq_r <= sq_r + sq_mc_r;
      end
      sq_mc_r <= sq_mc_r << 1;
      st_sh_r <= st_sh_r >> 1;
    end
    if (state_r == ST_FORM) begin
      den_r <= 75'(n_r) * 75'(stt_r) - 75'(sq_r);
    end
  end

  // Lane control
  swv_ctl_t ctl;
  always_comb begin
    ctl         = '0;
    ctl.clr     = accept;
    ctl.inc2    = inc2_r;
    ctl.mul_ld  = (state_r == ST_MUL) && (cnt_r == '0);
    ctl.mul_en  = (state_r == ST_MUL) && (cnt_r != '0);
    ctl.mul_bit = st_sh_r[0];
    ctl.form    = (state_r == ST_FORM);
    ctl.scl_en  = (state_r == ST_SCL);
    ctl.scl_idx = cnt_r[4:0];
    ctl.div_en  = (state_r == ST_DIV);
  end

  logic signed [31:0] vel_x, vel_y;

  swv_lane u_lane_x (
    .clk (clk), .ctl (ctl), .val (tail.x), .dt1 (dt1_r),
    .n (n_r), .den (den_r), .vel (vel_x)
  );

  swv_lane u_lane_y (
    .clk (clk), .ctl (ctl), .val (tail.y), .dt1 (dt1_r),
    .n (n_r), .den (den_r), .vel (vel_y)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 7'd1;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          state_nxt = full_nxt ? ST_ROT : ST_OUT;
        end
      end
      ST_ROT: begin
        if (cnt_r == 7'(WIN_MAX - 1)) begin
          state_nxt = ST_FLSH;
          cnt_nxt   = '0;
        end
      end
      ST_FLSH: begin
        if (cnt_r == 7'd1) begin
          state_nxt = ST_MUL;
          cnt_nxt   = '0;
        end
      end
      ST_MUL: begin
        if (cnt_r == 7'd37) begin
          state_nxt = ST_FORM;
          cnt_nxt   = '0;
        end
      end
      ST_FORM: begin
        state_nxt = ST_SCL;
        cnt_nxt   = '0;
      end
      ST_SCL: begin
        if (cnt_r == 7'd19) begin
          state_nxt = ST_DIV;
          cnt_nxt   = '0;
        end
      end
      ST_DIV: begin
        if (cnt_r == 7'd96) begin
          state_nxt = ST_OUT;
          cnt_nxt   = '0;
        end
      end
      ST_OUT: begin
        cnt_nxt = '0;
        if (!out_valid || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // Output register: hold while stalled, load from the lanes when free, or zeros while the window is still filling.
  swv_out_t out_r;
  logic     out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      wlen_r      <= 6'd8;
      fill_r      <= '0;
      full_r      <= 1'b0;
      n_r         <= 6'd1;
      inc1_r      <= 1'b0;
      inc2_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      inc1_r  <= incl;
      inc2_r  <= inc1_r;
      if (cfg_we) begin
        wlen_r <= cfg_wdata;
      end
      if (accept) begin
        fill_r <= fill_nxt;
        full_r <= full_nxt;
        n_r    <= n_nxt;
      end
      if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
      if (full_r) begin
        out_r <= '{vel_x: vel_x, vel_y: vel_y, valid_res: 1'b1};
      end else begin
        out_r <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SWV_ASSERT_NOW(a_zero_when_invalid, out_valid && !out_data.valid_res, out_data.vel_x == 0 && out_data.vel_y == 0)
  `SWV_ASSERT_NEXT(a_accept_starts, accept, state_r == ST_ROT || state_r == ST_OUT)
  `SWV_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= 6'(WIN_MAX))
  `SWV_ASSERT_NOW(a_n_range, state_r == ST_ROT, n_r >= 6'd1 && n_r <= fill_r)

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives timestamped position words into the sliding-window slope estimator,
// predicts each result with an exact wide-integer line fit, and checks every
// result word field by field under random gaps and output stalls.
// ---------------------------------------------------------------------------
module testbench;
  import swv_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  swv_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  swv_out_t out_data;
  logic     cfg_we;
  logic [5:0] cfg_wdata;

  sliding_window_ls_velocity_2d_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Pending sample words and expected velocity words
  swv_in_t  pending_samples[$];
  swv_out_t expected_vel[$];
  int       errors = 0;
  int       n_results = 0;
  int       n_valid_results = 0;
  int       gap_left;
  int       stall_left;

  // Shadow copy of the estimator state
  logic [31:0] ring_t[WIN_MAX] = '{default: '0};
  logic [31:0] ring_x[WIN_MAX] = '{default: '0};
  logic [31:0] ring_y[WIN_MAX] = '{default: '0};
  int          ring_wp = 0;
  int          ring_fill = 0;
  bit          ring_full = 1'b0;
  logic [5:0]  win_len_reg;

  // Stimulus generator state
  logic [31:0] gen_t;
  logic [31:0] gen_x;
  logic [31:0] gen_y;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Exact slope of one coordinate over n ring entries starting at slot first
  function automatic logic [31:0] line_slope(bit use_y, int first, int n);
    logic signed [127:0] num;
    logic signed [127:0] den;
    logic signed [127:0] dt;
    logic signed [127:0] dv;
    logic signed [127:0] q;
    logic [31:0] t0;
    logic [31:0] va;
    logic [31:0] vb;
    int a;
    int b;
    num = 0;
    den = 0;
    t0  = ring_t[first];
    for (int i = 0; i < n; i++) begin
      a  = (first + i) % WIN_MAX;
      va = use_y ? ring_y[a] : ring_x[a];
      for (int j = 0; j < i; j++) begin
        b  = (first + j) % WIN_MAX;
        vb = use_y ? ring_y[b] : ring_x[b];
        dt = $signed({96'd0, ring_t[a] - t0}) - $signed({96'd0, ring_t[b] - t0});
        dv = $signed({{96{va[31]}}, va}) - $signed({{96{vb[31]}}, vb});
        num += dt * dv;
        den += dt * dt;
      end
    end
    if (den == 0) return 32'd0;
    q = (num * 128'sd1000000) / den;
    if (q > 128'sd2147483647) return 32'h7FFF_FFFF;
    if (q < -128'sd2147483648) return 32'h8000_0000;
    return q[31:0];
  endfunction

  // Advance the shadow ring with an accepted word and queue its result
  task automatic predict_velocity(swv_in_t s);
    int len;
    int n;
    int first;
    swv_out_t r;
    len = win_len_reg;
    if (len < 1) len = 1;
    if (len > WIN_MAX) len = WIN_MAX;
    ring_x[ring_wp] = s.pos_x;
    ring_y[ring_wp] = s.pos_y;
    ring_t[ring_wp] = s.timestamp;
    ring_wp = (ring_wp + 1) % WIN_MAX;
    if (ring_fill < WIN_MAX) ring_fill++;
    if (ring_fill >= len) ring_full = 1'b1;
    r = '0;
    if (ring_full) begin
      n     = (ring_fill < len) ? ring_fill : len;
      first = (ring_wp + WIN_MAX - n) % WIN_MAX;
      r.vel_x     = line_slope(1'b0, first, n);
      r.vel_y     = line_slope(1'b1, first, n);
      r.valid_res = 1'b1;
    end
    expected_vel.insert(expected_vel.size(), r);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return $urandom_range(20, 90);
    if (r < 4) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Driver: hold a stalled word, advance to the next pending one otherwise
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) predict_velocity(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_data  <= pending_samples[0];
          pending_samples.delete(0);
          in_valid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    swv_out_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_vel.size() == 0) begin
          $error("result word with nothing expected: %h", out_data);
          errors++;
        end else begin
          e = expected_vel[0];
          expected_vel.delete(0);
          if (e.valid_res) n_valid_results++;
          if (out_data.vel_x !== e.vel_x) begin
            $error("vel_x expected %h actual %h", e.vel_x, out_data.vel_x);
            errors++;
          end
          if (out_data.vel_y !== e.vel_y) begin
            $error("vel_y expected %h actual %h", e.vel_y, out_data.vel_y);
            errors++;
          end
          if (out_data.valid_res !== e.valid_res) begin
            $error("valid_res expected %b actual %b", e.valid_res, out_data.valid_res);
            errors++;
          end
        end
      end
      // Stall runs: most short, a few long
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  task automatic add_sample(logic [31:0] x, logic [31:0] y, logic [31:0] t);
    swv_in_t s;
    s.pos_x     = x;
    s.pos_y     = y;
    s.timestamp = t;
    pending_samples.insert(pending_samples.size(), s);
  endtask

  // Wait until every queued word has come back and the core has gone quiet
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_samples.size() != 0 || in_valid || expected_vel.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_window(logic [5:0] v);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    win_len_reg = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly a moving track with random content; sometimes pure noise
  task automatic add_random(int count);
    int m;
    for (int k = 0; k < count; k++) begin
      m = $urandom_range(0, 9);
      if (m == 0) begin
        gen_x = $urandom;
        gen_y = $urandom;
        gen_t = $urandom;
      end else begin
        case ($urandom_range(0, 5))
          0: gen_t = gen_t;
          1: gen_t = gen_t + $urandom;
          default: gen_t = gen_t + $urandom_range(1, 100000);
        endcase
        if ($urandom_range(0, 19) == 0) gen_x = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        else gen_x = gen_x + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        if ($urandom_range(0, 19) == 0) gen_y = $urandom;
        else gen_y = gen_y + $signed($urandom_range(0, 1 << 24)) - (1 << 23);
      end
      add_sample(gen_x, gen_y, gen_t);
    end
  endtask

  initial begin
    logic [5:0] win_plan[11];
    win_plan = '{6'd1, 6'd2, 6'd32, 6'd0, 6'd63, 6'd3, 6'd8, 6'd17, 6'd31, 6'd5, 6'd12};
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    win_len_reg = 6'd8;
    gen_t = 32'hFFFF_0000;
    gen_x = '0;
    gen_y = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: filling, equal times, field extremes, timestamp wrap, saturation
    for (int i = 0; i < 4; i++) add_sample(32'h0001_0000 * i, -32'sh0002_0000 * i, 32'd1000);
    add_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFF0);
    add_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFF1);
    add_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0002);
    add_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0003);
    add_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0004);
    add_sample(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
    set_window(6'd20);
    // Window raised past the fill level: valid holds, fit uses what is stored
    add_sample(32'h0000_1234, 32'hFFFF_0000, 32'h8000_1000);
    add_sample(32'h0010_0000, 32'h0020_0000, 32'h8000_1001);
    set_window(6'd2);
    add_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0010);
    add_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0011);
    add_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0011);

    foreach (win_plan[p]) begin
      set_window(win_plan[p]);
      add_random(150);
    end
    wait_drained();
    repeat (250) @(posedge clk);
    $display("Checked %0d result words (%0d with a full window) over 13 window settings",
             n_results, n_valid_results);
    $display("including window lengths 0, 1, 2, 32 and 63, wrapped and equal timestamps");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
